// ===== hdl/wfps_pkg.sv =====
// Shared types, constants and the arctangent table of the wall-following steering core.
package wfps_pkg;

	localparam int VEC_W = 36;
	localparam int ANG_W = 34;
	localparam int MUL_B_W = 24;
	localparam int DIV_NUM_W = 60;
	localparam int ATAN_ENTRIES = 24;

	localparam logic [2:0] REG_GAIN_P = 3'd0;
	localparam logic [2:0] REG_GAIN_I = 3'd1;
	localparam logic [2:0] REG_GAIN_D = 3'd2;
	localparam logic [2:0] REG_DESIRED = 3'd3;
	localparam logic [2:0] REG_LOOKAHEAD = 3'd4;

	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [VEC_W-1:0] INV_GAIN_Q30 = 36'sd652032874;
	localparam logic signed [MUL_B_W-1:0] COS35_Q16 = 24'sd53684;
	localparam logic signed [MUL_B_W-1:0] SIN35_Q16 = 24'sd37590;
	localparam logic signed [MUL_B_W-1:0] USEC_PER_S = 24'sd1000000;
	localparam logic signed [MUL_B_W-1:0] SMOOTH_Q16 = 24'sd3277;

	localparam logic [15:0] SPEED_HIGH = 16'd20480;
	localparam logic [15:0] SPEED_MID = 16'd11264;
	localparam logic [15:0] SPEED_LOW = 16'd6144;
	localparam logic [15:0] SPEED_MIN = 16'd3072;
	localparam logic [16:0] LIMIT_5DEG = 17'd358;
	localparam logic [16:0] LIMIT_10DEG = 17'd715;
	localparam logic [16:0] LIMIT_30DEG = 17'd2145;

	typedef struct packed {
		logic [15:0] range_at_first_beam;
		logic [15:0] range_at_second_beam;
		logic [31:0] time_us;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] steering_angle;
		logic [14:0] speed_command;
		logic time_step_zero;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] mcand;
		logic signed [MUL_B_W-1:0] mplier;
		logic signed [63:0] init;
	} mul_req_t;

	typedef struct packed {
		logic start;
		logic vec_mode;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} cordic_req_t;

	typedef struct packed {
		logic start;
		logic [DIV_NUM_W-1:0] num;
		logic [31:0] den;
	} div_req_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0: v = 34'sd843314857;
			5'd1: v = 34'sd497837829;
			5'd2: v = 34'sd263043836;
			5'd3: v = 34'sd133525158;
			5'd4: v = 34'sd67021686;
			5'd5: v = 34'sd33543515;
			5'd6: v = 34'sd16775850;
			5'd7: v = 34'sd8388437;
			5'd8: v = 34'sd4194282;
			5'd9: v = 34'sd2097149;
			5'd10: v = 34'sd1048575;
			5'd11: v = 34'sd524287;
			5'd12: v = 34'sd262143;
			5'd13: v = 34'sd131071;
			5'd14: v = 34'sd65535;
			5'd15: v = 34'sd32767;
			5'd16: v = 34'sd16383;
			5'd17: v = 34'sd8191;
			5'd18: v = 34'sd4095;
			5'd19: v = 34'sd2047;
			5'd20: v = 34'sd1023;
			5'd21: v = 34'sd511;
			5'd22: v = 34'sd255;
			5'd23: v = 34'sd127;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/wfps_mul.sv =====
// Bit-serial signed shift-and-add multiplier with a preloadable accumulator.
module wfps_mul (
	input logic clk,
	input logic arst_n,
	input wfps_pkg::mul_req_t req,
	output logic done,
	output logic signed [63:0] product
);

	localparam int CNT_W = $clog2(wfps_pkg::MUL_B_W);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] mcand_q;
	logic [wfps_pkg::MUL_B_W-1:0] mplier_q;
	logic last;
	logic signed [63:0] addend;
	logic signed [63:0] acc_next;

	// The top multiplier bit carries negative weight, so it is subtracted.
	always_comb begin
		last = (cnt_q == CNT_W'(wfps_pkg::MUL_B_W - 1));
		addend = mplier_q[0] ? mcand_q : 64'sd0;
		acc_next = last ? (acc_q - addend) : (acc_q + addend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.init;
			mcand_q <= req.mcand;
			mplier_q <= req.mplier;
		end else if (busy_q) begin
			acc_q <= acc_next;
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign product = acc_q;

endmodule

// ===== hdl/wfps_div.sv =====
// Restoring unsigned divider producing one quotient bit per cycle.
module wfps_div (
	input logic clk,
	input logic arst_n,
	input wfps_pkg::div_req_t req,
	output logic done,
	output logic [wfps_pkg::DIV_NUM_W-1:0] quotient
);

	localparam int NW = wfps_pkg::DIV_NUM_W;
	localparam int CNT_W = $clog2(NW);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [NW-1:0] quo_q;
	logic [32:0] trial;
	logic ge;
	logic [32:0] rem_next;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge = (trial >= {1'b0, den_q});
		rem_next = ge ? (trial - {1'b0, den_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The numerator shifts out of the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= rem_next[31:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/wfps_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, in vectoring or rotation mode.
module wfps_cordic #(
	parameter int STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input wfps_pkg::cordic_req_t req,
	output logic done,
	output logic signed [wfps_pkg::VEC_W-1:0] x_out,
	output logic signed [wfps_pkg::VEC_W-1:0] y_out,
	output logic signed [wfps_pkg::ANG_W-1:0] z_out
);

	localparam int VW = wfps_pkg::VEC_W;
	localparam int AW = wfps_pkg::ANG_W;

	logic busy_q;
	logic done_q;
	logic vec_q;
	logic [4:0] i_q;
	logic signed [VW-1:0] x_q;
	logic signed [VW-1:0] y_q;
	logic signed [AW-1:0] z_q;
	logic signed [VW-1:0] x_sh;
	logic signed [VW-1:0] y_sh;
	logic signed [AW-1:0] ang;
	logic cw;
	logic last;
	logic zero_vec;

	always_comb begin
		x_sh = x_q >>> i_q;
		y_sh = y_q >>> i_q;
		ang = wfps_pkg::atan_entry(i_q);
		// Vectoring drives y toward zero, rotation drives z toward zero.
		cw = vec_q ? !y_q[VW-1] : z_q[AW-1];
		last = (i_q == 5'(STEPS - 1));
		zero_vec = (req.x == '0) && (req.y == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				i_q <= '0;
				if (req.vec_mode && zero_vec) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			vec_q <= req.vec_mode;
			if (req.vec_mode) begin
				if (zero_vec) begin
					x_q <= '0;
					y_q <= '0;
					z_q <= '0;
				end else if (req.x[VW-1]) begin
					// Pre-rotate a left-half vector by a quarter turn.
					x_q <= req.y;
					y_q <= -req.x;
					z_q <= wfps_pkg::HALF_PI_Q30;
				end else begin
					x_q <= req.x;
					y_q <= req.y;
					z_q <= '0;
				end
			end else if (req.z > wfps_pkg::HALF_PI_Q30) begin
				x_q <= '0;
				y_q <= wfps_pkg::INV_GAIN_Q30;
				z_q <= req.z - wfps_pkg::HALF_PI_Q30;
			end else begin
				x_q <= wfps_pkg::INV_GAIN_Q30;
				y_q <= '0;
				z_q <= req.z;
			end
		end else if (busy_q) begin
			if (cw) begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - ang;
			end
		end
	end

	assign done = done_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

// ===== hdl/wall_follow_pid_steering_core.sv =====
// Top level of the wall-following PID steering core: registers, sequencer and output stage.
//
// One request per lidar scan enters on in_valid/in_ready with the two beam ranges
// and the scan time stamp; one request leaves on out_valid/out_ready with the
// saturated steering angle, the smoothed speed and the zero time step flag.
// The user must write gains and distances over the APB port only while no scan is
// in flight; the block itself does not enforce it. A scan runs seven products
// on the shared bit-serial multiplier when its time step is zero and nine
// otherwise, two CORDIC passes, and, for a nonzero time step, the bit-serial
// divide of the derivative term. The multiplier sets the pace.
// Only one scan is processed at a time; in_ready is high only while the sequencer
// is idle. The finished result sits in an output register, so the next scan is
// taken while that result waits for out_ready; a stalled receiver holds the last
// step of the following scan until the output register frees up.
// Reset restores the default gains and distances and clears the error history,
// the integral, the last time stamp and the speed estimate.
module wall_follow_pid_steering_core #(
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input wfps_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output wfps_pkg::out_item_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int STEPS = (CORDIC_STEPS > wfps_pkg::ATAN_ENTRIES) ?
		wfps_pkg::ATAN_ENTRIES : CORDIC_STEPS;
	localparam int VW = wfps_pkg::VEC_W;
	localparam int AW = wfps_pkg::ANG_W;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_MUL_AC = 5'd1;
	localparam logic [4:0] ST_MUL_AS = 5'd2;
	localparam logic [4:0] ST_VEC = 5'd3;
	localparam logic [4:0] ST_ROT = 5'd4;
	localparam logic [4:0] ST_MUL_BC = 5'd5;
	localparam logic [4:0] ST_MUL_LS = 5'd6;
	localparam logic [4:0] ST_ERR = 5'd7;
	localparam logic [4:0] ST_SUM = 5'd8;
	localparam logic [4:0] ST_MUL_P = 5'd9;
	localparam logic [4:0] ST_MUL_I = 5'd10;
	localparam logic [4:0] ST_MUL_D = 5'd11;
	localparam logic [4:0] ST_MUL_DS = 5'd12;
	localparam logic [4:0] ST_DIV = 5'd13;
	localparam logic [4:0] ST_STEER = 5'd14;
	localparam logic [4:0] ST_MUL_SP = 5'd15;
	localparam logic [4:0] ST_OUT = 5'd16;

	localparam logic signed [23:0] E_MAX = 24'h7FFFFF;
	localparam logic signed [23:0] E_MIN = 24'h800000;
	localparam logic signed [31:0] S_MAX = 32'h7FFFFFFF;
	localparam logic signed [31:0] S_MIN = 32'h80000000;
	localparam logic signed [15:0] T_MAX = 16'h7FFF;
	localparam logic signed [15:0] T_MIN = 16'h8000;

	logic [4:0] state_q;
	logic go_q;
	logic out_valid_q;
	wfps_pkg::out_item_t out_data_q;

	logic signed [15:0] kp_q;
	logic signed [15:0] ki_q;
	logic signed [15:0] kd_q;
	logic [15:0] desired_q;
	logic [15:0] lookahead_q;

	logic signed [23:0] last_error_q;
	logic signed [31:0] error_sum_q;
	logic [31:0] last_time_q;
	logic [15:0] speed_q;

	logic [15:0] a_q;
	logic [15:0] b_q;
	logic [31:0] time_q;
	logic [31:0] dt_q;
	logic zero_q;
	logic signed [VW-1:0] xv_q;
	logic signed [VW-1:0] yv_q;
	logic signed [AW-1:0] alpha_q;
	logic signed [VW-1:0] c_q;
	logic signed [VW-1:0] s_q;
	logic signed [23:0] e_q;
	logic signed [31:0] sum_q;
	logic signed [24:0] de_q;
	logic signed [63:0] pi_q;
	logic neg_q;
	logic [wfps_pkg::DIV_NUM_W-1:0] mag_q;
	logic signed [63:0] acc_q;
	logic signed [15:0] steer_q;

	wfps_pkg::mul_req_t mul_req;
	wfps_pkg::cordic_req_t cor_req;
	wfps_pkg::div_req_t div_req;
	logic mul_done;
	logic signed [63:0] mul_prod;
	logic cor_done;
	logic signed [VW-1:0] cor_x;
	logic signed [VW-1:0] cor_y;
	logic signed [AW-1:0] cor_z;
	logic div_done;
	logic [wfps_pkg::DIV_NUM_W-1:0] div_quo;

	logic in_acc;
	logic cfg_wr;
	logic unit_done;
	logic signed [63:0] e_full;
	logic signed [23:0] e_next;
	logic signed [33:0] sum_wide;
	logic signed [31:0] sum_next;
	logic signed [63:0] t_full;
	logic signed [15:0] steer_next;
	logic signed [16:0] st17;
	logic [16:0] mag;
	logic [15:0] target;
	logic signed [16:0] diff;
	logic signed [63:0] prod_mag;
	logic signed [63:0] q_signed;

	wfps_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req),
		.done(mul_done),
		.product(mul_prod)
	);

	wfps_cordic #(.STEPS(STEPS)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.req(cor_req),
		.done(cor_done),
		.x_out(cor_x),
		.y_out(cor_y),
		.z_out(cor_z)
	);

	wfps_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.done(div_done),
		.quotient(div_quo)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		case (paddr[4:2])
			wfps_pkg::REG_GAIN_P: prdata = {16'd0, kp_q};
			wfps_pkg::REG_GAIN_I: prdata = {16'd0, ki_q};
			wfps_pkg::REG_GAIN_D: prdata = {16'd0, kd_q};
			wfps_pkg::REG_DESIRED: prdata = {16'd0, desired_q};
			wfps_pkg::REG_LOOKAHEAD: prdata = {16'd0, lookahead_q};
			default: prdata = '0;
		endcase
	end

	// Operand selection for the shared units; each start is a single-cycle pulse.
	always_comb begin
		mul_req = '0;
		cor_req = '0;
		div_req = '0;
		case (state_q)
			ST_MUL_AC: begin
				mul_req.start = !go_q;
				mul_req.mcand = 64'(wfps_pkg::COS35_Q16);
				mul_req.mplier = 24'(a_q);
			end
			ST_MUL_AS: begin
				mul_req.start = !go_q;
				mul_req.mcand = 64'(wfps_pkg::SIN35_Q16);
				mul_req.mplier = 24'(a_q);
			end
			ST_VEC: begin
				cor_req.start = !go_q;
				cor_req.vec_mode = 1'b1;
				cor_req.x = xv_q;
				cor_req.y = yv_q;
			end
			ST_ROT: begin
				cor_req.start = !go_q;
				cor_req.z = alpha_q;
			end
			ST_MUL_BC: begin
				mul_req.start = !go_q;
				mul_req.mcand = -64'(c_q);
				mul_req.mplier = 24'(b_q);
				mul_req.init = (64'(desired_q) << 30) + 64'sd536870912;
			end
			ST_MUL_LS: begin
				mul_req.start = !go_q;
				mul_req.mcand = -64'(s_q);
				mul_req.mplier = 24'(lookahead_q);
				mul_req.init = mul_prod;
			end
			ST_MUL_P: begin
				mul_req.start = !go_q;
				mul_req.mcand = 64'(e_q);
				mul_req.mplier = 24'(kp_q);
			end
			ST_MUL_I: begin
				mul_req.start = !go_q;
				mul_req.mcand = 64'(sum_q);
				mul_req.mplier = 24'(ki_q);
				mul_req.init = mul_prod;
			end
			ST_MUL_D: begin
				mul_req.start = !go_q;
				mul_req.mcand = 64'(de_q);
				mul_req.mplier = 24'(kd_q);
			end
			ST_MUL_DS: begin
				mul_req.start = !go_q;
				mul_req.mcand = mul_prod;
				mul_req.mplier = wfps_pkg::USEC_PER_S;
			end
			ST_DIV: begin
				div_req.start = !go_q;
				div_req.num = mag_q;
				div_req.den = dt_q;
			end
			ST_MUL_SP: begin
				mul_req.start = !go_q;
				mul_req.mcand = 64'(diff);
				mul_req.mplier = wfps_pkg::SMOOTH_Q16;
				mul_req.init = 64'sd32768;
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	always_comb begin
		unit_done = mul_done || cor_done || div_done;

		e_full = mul_prod >>> 30;
		if (e_full > 64'(E_MAX)) begin
			e_next = E_MAX;
		end else if (e_full < 64'(E_MIN)) begin
			e_next = E_MIN;
		end else begin
			e_next = e_full[23:0];
		end

		sum_wide = 34'(error_sum_q) + 34'(e_q);
		if (sum_wide > 34'(S_MAX)) begin
			sum_next = S_MAX;
		end else if (sum_wide < 34'(S_MIN)) begin
			sum_next = S_MIN;
		end else begin
			sum_next = sum_wide[31:0];
		end

		t_full = (acc_q + 64'sd32) >>> 6;
		if (t_full > 64'(T_MAX)) begin
			steer_next = T_MAX;
		end else if (t_full < 64'(T_MIN)) begin
			steer_next = T_MIN;
		end else begin
			steer_next = t_full[15:0];
		end

		st17 = 17'(steer_q);
		mag = st17[16] ? 17'(-st17) : 17'(st17);
		if (mag < wfps_pkg::LIMIT_5DEG) begin
			target = wfps_pkg::SPEED_HIGH;
		end else if (mag < wfps_pkg::LIMIT_10DEG) begin
			target = wfps_pkg::SPEED_MID;
		end else if (mag < wfps_pkg::LIMIT_30DEG) begin
			target = wfps_pkg::SPEED_LOW;
		end else begin
			target = wfps_pkg::SPEED_MIN;
		end
		diff = $signed({1'b0, target}) - $signed({1'b0, speed_q});

		prod_mag = mul_prod[63] ? -mul_prod : mul_prod;
		q_signed = neg_q ? -$signed({4'd0, div_quo}) : $signed({4'd0, div_quo});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q <= 1'b0;
			out_valid_q <= 1'b0;
			kp_q <= 16'sd512;
			ki_q <= 16'sd0;
			kd_q <= 16'sd26;
			desired_q <= 16'd614;
			lookahead_q <= 16'd512;
			last_error_q <= '0;
			error_sum_q <= '0;
			last_time_q <= '0;
			speed_q <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[4:2])
					wfps_pkg::REG_GAIN_P: kp_q <= pwdata[15:0];
					wfps_pkg::REG_GAIN_I: ki_q <= pwdata[15:0];
					wfps_pkg::REG_GAIN_D: kd_q <= pwdata[15:0];
					wfps_pkg::REG_DESIRED: desired_q <= pwdata[15:0];
					wfps_pkg::REG_LOOKAHEAD: lookahead_q <= pwdata[15:0];
					default: ;
				endcase
			end

			// The output stage reloads the register itself when a result leaves.
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					go_q <= 1'b0;
					if (in_acc) begin
						state_q <= ST_MUL_AC;
					end
				end
				ST_ERR: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_MUL_P;
				ST_STEER: begin
					last_error_q <= e_q;
					error_sum_q <= sum_q;
					last_time_q <= time_q;
					state_q <= ST_MUL_SP;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					if (!go_q) begin
						go_q <= 1'b1;
					end else if (unit_done) begin
						go_q <= 1'b0;
						case (state_q)
							ST_MUL_AC: state_q <= ST_MUL_AS;
							ST_MUL_AS: state_q <= ST_VEC;
							ST_VEC: state_q <= ST_ROT;
							ST_ROT: state_q <= ST_MUL_BC;
							ST_MUL_BC: state_q <= ST_MUL_LS;
							ST_MUL_LS: state_q <= ST_ERR;
							ST_MUL_P: state_q <= ST_MUL_I;
							ST_MUL_I: state_q <= zero_q ? ST_STEER : ST_MUL_D;
							ST_MUL_D: state_q <= ST_MUL_DS;
							ST_MUL_DS: state_q <= ST_DIV;
							ST_DIV: state_q <= ST_STEER;
							ST_MUL_SP: begin
								speed_q <= speed_q + mul_prod[31:16];
								state_q <= ST_OUT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q <= in_data.range_at_first_beam;
			b_q <= in_data.range_at_second_beam;
			time_q <= in_data.time_us;
			dt_q <= in_data.time_us - last_time_q;
			zero_q <= (in_data.time_us == last_time_q);
		end
		if (go_q && unit_done) begin
			case (state_q)
				ST_MUL_AC: xv_q <= VW'(mul_prod - (64'(b_q) << 16));
				ST_MUL_AS: yv_q <= mul_prod[VW-1:0];
				ST_VEC: alpha_q <= cor_z;
				ST_ROT: begin
					c_q <= cor_x;
					s_q <= cor_y;
				end
				ST_MUL_I: begin
					pi_q <= mul_prod;
					acc_q <= mul_prod;
				end
				ST_MUL_DS: begin
					neg_q <= mul_prod[63];
					mag_q <= prod_mag[wfps_pkg::DIV_NUM_W-1:0];
				end
				ST_DIV: acc_q <= pi_q + q_signed;
				default: ;
			endcase
		end
		if (state_q == ST_ERR) begin
			e_q <= e_next;
		end
		if (state_q == ST_SUM) begin
			sum_q <= sum_next;
			de_q <= 25'(e_q) - 25'(last_error_q);
		end
		if (state_q == ST_STEER) begin
			steer_q <= steer_next;
		end
		if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
			out_data_q.steering_angle <= steer_q;
			out_data_q.speed_command <= speed_q[14:0];
			out_data_q.time_step_zero <= zero_q;
		end
	end

endmodule

// ===== hdl/wfps_checker.sv =====
// Port-level checks on the steering core and the bind that attaches them.
module wfps_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input wfps_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input wfps_pkg::out_item_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic pready
);

	// A held result must not change under a stalled receiver.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Scans are processed one at a time, so an accepted request drops in_ready.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted request");

	// Smoothing never overshoots the highest speed target.
	a_speed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.speed_command <= 15'd20480)
		else $error("speed command above the top target");

	// All registers are 16 bits wide and the port never inserts wait states.
	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		pready && (prdata[31:16] == 16'd0))
		else $error("configuration read data out of range");

endmodule

bind wall_follow_pid_steering_core wfps_checker u_wfps_checker (.*);
